>>> rtl/incremental_prime_sieve_defines.svh
// Assertion macros used by the checker file of the incremental prime sieve.
// No dependencies; included by files that carry concurrent assertions.
`ifndef INCREMENTAL_PRIME_SIEVE_DEFINES_SVH
`define INCREMENTAL_PRIME_SIEVE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define IPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the same cycle.
`define IPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  `IPS_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// Implication checked in the next cycle.
`define IPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  `IPS_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

>>> rtl/ips_pkg.sv
// Shared types and constants of the incremental prime sieve.
// No dependencies; imported by every module of the block.
package ips_pkg;

  localparam int unsigned TABLE_DEPTH  = 8192;
  localparam int unsigned ADDR_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W        = ADDR_W + 1;
  localparam int unsigned NUM_W        = 32;
  localparam int unsigned CAND_W       = 33;
  localparam int unsigned PRIME_W      = 16;
  localparam int unsigned SQ_W         = 2 * PRIME_W;
  localparam int unsigned MULT_W       = 33;
  localparam int unsigned LIMIT_W      = 32;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000);
  localparam logic [CAND_W-1:0]  FIRST_CAND  = CAND_W'(2);

  // One table entry: a stored prime and its next multiple.
  typedef struct packed {
    logic [PRIME_W-1:0] prime;
    logic [MULT_W-1:0]  mult;
  } entry_t;

  // Table access driven by the walker.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // One result item.
  typedef struct packed {
    logic             past_limit;
    logic             is_prime;
    logic [NUM_W-1:0] number;
  } result_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_FETCH = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_ADV   = 7'b0001000,
    ST_SQR   = 7'b0010000,
    ST_STORE = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

endpackage

>>> rtl/incremental_prime_sieve.sv
// Incremental prime sieve top level: limit register, walker, table and output register.
// Depends on ips_pkg, ips_table and ips_walker.
//
// Each input item tests the next integer, counting up from 2 (or restarts at 2 when
// tdata bit 0 is set), and yields one result item with the number and its prime and
// past-limit flags. A new item is accepted only in the idle state, once the previous
// result has been taken by the output register. The walk is paced by the single read
// port of the table memory, read once per prime, and the one adder that advances a
// multiple by one step per cycle. The result enters the output register as the walker
// returns to idle, and the next item is accepted while that result still waits there.
// The table needs no clearing after reset.
module incremental_prime_sieve
  import ips_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               upper_limit_we_i,
  input  logic [LIMIT_W-1:0] upper_limit_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [0] restart, [7:1] zero fill
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [NUM_W-1:0]   m_axis_tdata,   // [31:0] number
  output logic [1:0]         m_axis_tuser    // [0] is_prime, [1] past_limit
);

  logic [LIMIT_W-1:0] limit_q;
  logic               out_valid_q;
  result_t            out_q;
  logic               res_valid;
  logic               res_ready;
  result_t            res;
  mem_req_t           mem_req;
  entry_t             mem_rdata;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (upper_limit_we_i) begin
      limit_q <= upper_limit_i;
    end
  end

  ips_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (s_axis_tvalid & s_axis_tready),
    .restart_i   (s_axis_tdata[0]),
    .limit_i     (limit_q),
    .ready_o     (s_axis_tready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .mem_o       (mem_req),
    .rdata_i     (mem_rdata)
  );

  ips_table u_table (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Output register: refilled when empty or when its item leaves this cycle.
  assign res_ready = ~out_valid_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.number;
  assign m_axis_tuser  = {out_q.past_limit, out_q.is_prime};

endmodule

>>> rtl/ips_table.sv
// Prime and multiple table: one write port, one registered read port.
// Depends on ips_pkg for the depth and the entry layout.
module ips_table
  import ips_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output entry_t   rdata_o
);

  entry_t mem [TABLE_DEPTH];
  entry_t rdata_q;

  // Write and read in the same clocked block; read data is registered and ready in the next cycle.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ips_walker.sv
// Sequencer of the sieve: walks the table for one number and updates it.
// Depends on ips_pkg; drives the table in ips_table.
module ips_walker
  import ips_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               restart_i,
  input  logic [LIMIT_W-1:0] limit_i,
  output logic               ready_o,
  output logic               res_valid_o,
  output result_t            res_o,
  input  logic               res_ready_i,
  output mem_req_t           mem_o,
  input  entry_t             rdata_i
);

  state_e              state_q, state_d;
  logic [CAND_W-1:0]   cand_q, cand_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    k_q, k_d;
  logic [CAND_W-1:0]   n_q, n_d;
  logic [PRIME_W-1:0]  p_q, p_d;
  logic [MULT_W-1:0]   m_q, m_d;
  logic [SQ_W-1:0]     sq_q, sq_d;
  logic                prime_q, prime_d;
  logic                past_q, past_d;
  logic [CAND_W-1:0]   first_n;
  logic [PRIME_W-1:0]  mul_a;
  logic [CAND_W-1:0]   n_inc;
  logic                may_store;

  // One shared 16x16 multiplier: prime squares in ST_MUL, the candidate square otherwise.
  assign mul_a   = (state_q == ST_MUL) ? rdata_i.prime : n_q[PRIME_W-1:0];
  assign first_n = restart_i ? FIRST_CAND : cand_q;
  assign n_inc   = n_q + CAND_W'(1);

  // A prime is kept only when its square stays within the limit and room is left.
  assign may_store = (n_q[CAND_W-1:PRIME_W] == '0) && (sq_q <= limit_i)
                     && (count_q < CNT_W'(TABLE_DEPTH));

  always_comb begin
    state_d = state_q;
    cand_d  = cand_q;
    count_d = count_q;
    k_d     = k_q;
    n_d     = n_q;
    p_d     = p_q;
    m_d     = m_q;
    sq_d    = sq_q;
    prime_d = prime_q;
    past_d  = past_q;
    mem_o.we    = 1'b0;
    mem_o.waddr = k_q[ADDR_W-1:0];
    mem_o.wdata = '{prime: p_q, mult: m_q};
    mem_o.raddr = k_q[ADDR_W-1:0];

    case (state_q)
      // Take an item; a restart empties the table and starts over at two.
      ST_IDLE: begin
        if (start_i) begin
          if (restart_i) begin
            count_d = '0;
          end
          cand_d = first_n;
          n_d    = first_n;
          k_d    = '0;
          if (first_n > {1'b0, limit_i}) begin
            past_d  = 1'b1;
            prime_d = 1'b0;
            state_d = ST_DONE;
          end else begin
            past_d  = 1'b0;
            state_d = ST_FETCH;
          end
        end
      end
      // Read address k is presented; the end of the table means no divisor was found.
      ST_FETCH: begin
        if (k_q < count_q) begin
          state_d = ST_MUL;
        end else begin
          state_d = ST_SQR;
        end
      end
      // Table data arrives; register the entry and the square of its prime.
      ST_MUL: begin
        p_d     = rdata_i.prime;
        m_d     = rdata_i.mult;
        sq_d    = SQ_W'(mul_a) * SQ_W'(mul_a);
        state_d = ST_ADV;
      end
      // Stop when p*p passes n; else step the multiple by p up to n, then write it back.
      ST_ADV: begin
        if ({1'b0, sq_q} > n_q) begin
          state_d = ST_SQR;
        end else if (m_q < n_q) begin
          m_d = m_q + MULT_W'(p_q);
        end else begin
          mem_o.we = 1'b1;
          if (m_q == n_q) begin
            prime_d = 1'b0;
            cand_d  = n_inc;
            state_d = ST_DONE;
          end else begin
            k_d     = k_q + CNT_W'(1);
            state_d = ST_FETCH;
          end
        end
      end
      // n is prime; form its square for the storage test.
      ST_SQR: begin
        prime_d = 1'b1;
        sq_d    = SQ_W'(mul_a) * SQ_W'(mul_a);
        state_d = ST_STORE;
      end
      // Append the new prime with its square as first multiple, when it may be stored.
      ST_STORE: begin
        mem_o.waddr = count_q[ADDR_W-1:0];
        mem_o.wdata = '{prime: n_q[PRIME_W-1:0], mult: MULT_W'(sq_q)};
        if (may_store) begin
          mem_o.we = 1'b1;
          count_d  = count_q + CNT_W'(1);
        end
        cand_d  = n_inc;
        state_d = ST_DONE;
      end
      // Hold the result until the output register takes it.
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cand_q  <= FIRST_CAND;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      cand_q  <= cand_d;
      count_q <= count_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    n_q     <= n_d;
    p_q     <= p_d;
    m_q     <= m_d;
    sq_q    <= sq_d;
    prime_q <= prime_d;
    past_q  <= past_d;
  end

  assign ready_o          = (state_q == ST_IDLE);
  assign res_valid_o      = (state_q == ST_DONE);
  assign res_o.past_limit = past_q;
  assign res_o.is_prime   = prime_q & ~past_q;
  assign res_o.number     = past_q ? '0 : n_q[NUM_W-1:0];

endmodule

>>> rtl/ips_checker.sv
// Port-level checks of the incremental prime sieve, bound to its top level.
// Depends on ips_pkg and the macros in incremental_prime_sieve_defines.svh.
`include "incremental_prime_sieve_defines.svh"

module ips_checker
  import ips_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [NUM_W-1:0]   m_axis_tdata,
  input logic [1:0]         m_axis_tuser
);

  logic out_past;
  logic out_prime;

  assign out_past  = m_axis_tuser[1];
  assign out_prime = m_axis_tuser[0];

  // A stalled result item keeps its contents.
  `IPS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // A past-limit item carries no number and no prime flag.
  `IPS_ASSERT_IMP(a_past_clean, clk_i, rst_ni, m_axis_tvalid && out_past, (m_axis_tdata == '0) && !out_prime, "past-limit item with data")

  // Two is always reported prime.
  `IPS_ASSERT_IMP(a_two_prime, clk_i, rst_ni, m_axis_tvalid && !out_past && (m_axis_tdata == NUM_W'(2)), out_prime, "two reported composite")

  // A tested number is never below two.
  `IPS_ASSERT_IMP(a_num_floor, clk_i, rst_ni, m_axis_tvalid && !out_past, m_axis_tdata >= NUM_W'(2), "tested number below two")

endmodule

bind incremental_prime_sieve ips_checker u_ips_checker (.*);

>>> dv/tb_top.sv
// Self-checking testbench of the incremental prime sieve: restart items in, tested numbers out.
// Depends on ips_pkg and incremental_prime_sieve; holds its own sieve to predict each result.
`timescale 1ns / 1ps

module tb_top;
  import ips_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned LONG_HOLD     = 400;

  logic                clk_i    = 1'b0;
  logic                rst_n    = 1'b0;
  logic                cfg_we   = 1'b0;
  logic [LIMIT_W-1:0]  cfg_data = '0;
  logic                s_valid  = 1'b0;
  logic [7:0]          s_data   = '0;
  logic                m_ready  = 1'b0;
  logic                s_axis_tready;
  logic                m_axis_tvalid;
  logic [NUM_W-1:0]    m_axis_tdata;
  logic [1:0]          m_axis_tuser;

  // Sieve state kept alongside the block.
  logic [LIMIT_W-1:0]  limit_q     = LIMIT_RESET;
  logic [CAND_W-1:0]   next_number = FIRST_CAND;
  int unsigned         prime_count = 0;
  logic [PRIME_W-1:0]  prime_store [TABLE_DEPTH];
  logic [MULT_W-1:0]   mult_store  [TABLE_DEPTH];

  result_t             pending_results[$];
  int unsigned         mismatches      = 0;
  int unsigned         cycle_count     = 0;
  int unsigned         hold_cycles_req = 0;
  bit                  steady_flow     = 1'b0;

  incremental_prime_sieve uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .upper_limit_we_i (cfg_we),
    .upper_limit_i    (cfg_data),
    .s_axis_tvalid    (s_valid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_data),        // [0] restart, [7:1] zero fill
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_ready),
    .m_axis_tdata     (m_axis_tdata),  // [31:0] number
    .m_axis_tuser     (m_axis_tuser)   // [0] is_prime, [1] past_limit
  );

  // Free-running clock and cycle counter.
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Idle cycles before the next item on either side.
  function automatic int draw_gap();
    return steady_flow ? 0 : $urandom_range(0, 4);
  endfunction

  // Walks the stored primes whose square is at most n and advances their multiples.
  // Returns 0 as soon as a multiple lands exactly on n.
  function automatic bit sieve_walk(longint unsigned n);
    longint unsigned p;
    longint unsigned m;
    for (int k = 0; k < prime_count && k < TABLE_DEPTH; k++) begin
      p = prime_store[k];
      if (p == 0) continue;
      if (p * p > n) break;
      m = mult_store[k];
      if (m < n) m += ((n - m + p - 1) / p) * p;
      mult_store[k] = MULT_W'(m);
      if (m == n) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Tests the next number and updates the sieve state, as the block does for one item.
  function automatic result_t predict_sieve_result(bit restart);
    result_t         res;
    longint unsigned n;
    bit              prime;
    res = '0;
    if (restart) begin
      prime_count = 0;
      next_number = FIRST_CAND;
    end
    n = next_number;
    if (n > limit_q) begin
      // Past the limit nothing is tested and the state stays as it is.
      res.past_limit = 1'b1;
      return res;
    end
    prime = sieve_walk(n);
    if (prime && n * n <= limit_q && prime_count < TABLE_DEPTH) begin
      prime_store[prime_count] = PRIME_W'(n);
      mult_store[prime_count]  = MULT_W'(n * n);
      prime_count++;
    end
    next_number  = CAND_W'(n + 1);
    res.number   = NUM_W'(n);
    res.is_prime = prime;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // Offers one item after a random gap and records its expected result on acceptance.
  // The valid stays high afterward so that back-to-back items need no toggle.
  task automatic send_sieve_item(input bit restart);
    int      gap;
    result_t expected;
    gap = draw_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {7'b0, restart};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected = predict_sieve_result(restart);
    pending_results = {pending_results, expected};
  endtask

  // Stops offering items and waits until every expected result has arrived.
  task automatic wait_for_results();
    s_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes the limit register once the block is idle.
  task automatic write_upper_limit(input logic [LIMIT_W-1:0] value);
    wait_for_results();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk_i);
    limit_q = value;
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_run(input int count, input int restart_odds);
    for (int i = 0; i < count; i++) begin
      send_sieve_item($urandom_range(1, restart_odds) == 1);
    end
  endtask

  // Compares one accepted result with the oldest expectation.
  task automatic check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result number=%0d with no item pending", m_axis_tdata));
      return;
    end
    want = pending_results.pop_front();
    if (m_axis_tdata !== want.number)
      report_mismatch($sformatf("number got %0d expected %0d", m_axis_tdata, want.number));
    if (m_axis_tuser[0] !== want.is_prime)
      report_mismatch($sformatf("is_prime got %b expected %b for number %0d",
                                m_axis_tuser[0], want.is_prime, want.number));
    if (m_axis_tuser[1] !== want.past_limit)
      report_mismatch($sformatf("past_limit got %b expected %b for number %0d",
                                m_axis_tuser[1], want.past_limit, want.number));
  endtask

  // Result side: random stalls, plus one long hold-off when a test asks for it.
  initial begin : result_sink
    int stall;
    int held;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_cycles_req > 0) begin
        held = hold_cycles_req;
        hold_cycles_req = 0;
        m_ready <= 1'b0;
        repeat (held) @(posedge clk_i);
      end
      stall = draw_gap();
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      check_result();
    end
  end

  // Reset limit of 1000; first number 2 with and without a restart.
  task automatic test_reset_defaults();
    send_sieve_item(1'b0);
    send_sieve_item(1'b1);
    send_sieve_item(1'b0);
    send_sieve_item(1'b0);
  endtask

  // A limit below two reports every item as past the limit, restart or not.
  task automatic test_limit_below_two();
    write_upper_limit('0);
    send_sieve_item(1'b0);
    send_sieve_item(1'b1);
    write_upper_limit(LIMIT_W'(1));
    send_sieve_item(1'b1);
  endtask

  // Counting past a small limit, staying there, and restarting from 2.
  task automatic test_past_limit();
    write_upper_limit(LIMIT_W'(3));
    send_sieve_item(1'b1);
    repeat (3) send_sieve_item(1'b0);
    send_sieve_item(1'b1);
  endtask

  // Raising the limit without a restart: 3 was never stored, so 9 comes out prime.
  task automatic test_limit_raised_mid_run();
    write_upper_limit(LIMIT_W'(4));
    send_sieve_item(1'b1);
    repeat (2) send_sieve_item(1'b0);
    write_upper_limit(LIMIT_RESET);
    repeat (5) send_sieve_item(1'b0);
  endtask

  // Largest limit: every prime found is stored, long counting runs.
  task automatic test_random_full_limit();
    write_upper_limit('1);
    send_sieve_item(1'b1);
    send_random_run(400, 256);
  endtask

  // Small limits with frequent restarts so the past-limit state is left often.
  task automatic test_random_small_limit();
    write_upper_limit(LIMIT_W'($urandom_range(2, 60)));
    send_sieve_item(1'b1);
    send_random_run(120, 8);
  endtask

  // Back to the default limit and random limits, continuing without a restart.
  task automatic test_random_mixed_limits();
    write_upper_limit(LIMIT_RESET);
    send_random_run(300, 256);
    write_upper_limit($urandom());
    send_random_run(200, 64);
  endtask

  // A stretch with no idle cycles on either side.
  task automatic test_steady_stream();
    write_upper_limit(LIMIT_W'($urandom_range(2, 2000)));
    steady_flow = 1'b1;
    send_sieve_item(1'b1);
    send_random_run(200, 128);
    wait_for_results();
    steady_flow = 1'b0;
  endtask

  // The result side holds off for a long time while items keep coming.
  task automatic test_output_backpressure();
    write_upper_limit('1);
    hold_cycles_req = LONG_HOLD;
    send_random_run(60, 256);
  endtask

  // The sender pauses until every result is back, then goes on without a restart.
  task automatic test_drain_pause();
    send_random_run(50, 256);
    wait_for_results();
    send_random_run(50, 256);
  endtask

  initial begin : test_sequence
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_limit_below_two();
    test_past_limit();
    test_limit_raised_mid_run();
    test_random_full_limit();
    test_random_small_limit();
    test_random_mixed_limits();
    test_steady_stream();
    test_output_backpressure();
    test_drain_pause();
    wait_for_results();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Ends a hung run.
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ips_pkg.sv
rtl/ips_table.sv
rtl/ips_walker.sv
rtl/incremental_prime_sieve.sv
rtl/ips_checker.sv
dv/tb_top.sv
